### rtl/core/iqed_pkg.sv
package iqed_pkg;

   // Controller states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MAG_READ,
      ST_MAG_START,
      ST_MAG_ROOT,
      ST_DIVIDE,
      ST_OUT_READ,
      ST_OUT_SEND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // store the accepted sample, update minima
      logic clear_ptr;   // reset the pass pointer
      logic start_root;  // launch a square root on the read sample
      logic root_ok;     // accumulate finished root, store magnitude
      logic start_div;   // launch the mean division
      logic next_ptr;    // advance the pass pointer
      logic out_load;    // capture a result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;        // this load fills the store
      logic root_done;
      logic div_done;
      logic ptr_last;    // pass pointer is on the last stored sample
   } status_type;

endpackage

### rtl/core/iqed_if.sv
interface iqed_req_if #(parameter int SW = 16);
   logic valid;
   logic ready;
   logic signed [SW-1:0] in_phase;
   logic signed [SW-1:0] quadrature;
   logic final_sample;
   modport source (output valid, in_phase, quadrature, final_sample, input ready);
   modport sink (input valid, in_phase, quadrature, final_sample, output ready);
endinterface

interface iqed_rsp_if;
   logic valid;
   logic ready;
   logic signed [17:0] envelope_less_mean;
   logic end_of_block;
   modport source (output valid, envelope_less_mean, end_of_block, input ready);
   modport sink (input valid, envelope_less_mean, end_of_block, output ready);
endinterface

### rtl/core/iqed_ram.sv
module iqed_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### rtl/core/iqed_ctrl.sv
module iqed_ctrl import iqed_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_final,
   input  logic       rsp_busy,
   input  logic       rsp_ready,
   output logic       req_ready,
   output logic       last_flag,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      last_flag = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_final || status.full) begin
                  cmd.clear_ptr = 1'b1;
                  state_in = ST_MAG_READ;
               end
            end
         end
         ST_MAG_READ: begin
            // The sample stores register their read, so the addressed entry appears in the next state.
            state_in = ST_MAG_START;
         end
         ST_MAG_START: begin
            cmd.start_root = 1'b1;
            state_in = ST_MAG_ROOT;
         end
         ST_MAG_ROOT: begin
            if (status.root_done) begin
               cmd.root_ok = 1'b1;
               if (status.ptr_last) begin
                  cmd.start_div = 1'b1;
                  cmd.clear_ptr = 1'b1;
                  state_in = ST_DIVIDE;
               end else begin
                  cmd.next_ptr = 1'b1;
                  state_in = ST_MAG_READ;
               end
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_OUT_READ;
            end
         end
         ST_OUT_READ: begin
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (!rsp_busy || rsp_ready) begin
               cmd.out_load = 1'b1;
               last_flag = status.ptr_last;
               if (status.ptr_last) begin
                  state_in = ST_LOAD;
               end else begin
                  cmd.next_ptr = 1'b1;
                  state_in = ST_OUT_READ;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

`ifndef SYNTHESIS
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_LOAD |-> !cmd.load) else $error("load outside load state");
   a_div_after_roots: assert property (@(posedge clock) disable iff (reset)
      cmd.start_div |=> state_ff == ST_DIVIDE) else $error("divide not entered");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> state_ff == ST_OUT_SEND) else $error("stray output load");
`endif
endmodule

### rtl/core/iqed_datapath.sv
module iqed_datapath import iqed_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int SW    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic signed [SW-1:0] in_i,
   input  logic signed [SW-1:0] in_q,
   input  cmd_type              cmd,
   input  logic                 last_flag,
   input  logic                 rsp_ready,
   output status_type           status,
   output logic                 rsp_valid,
   output logic signed [17:0]   rsp_data,
   output logic                 rsp_last
);
   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int OW  = SW + 1;            // offset sample width, unsigned
   localparam int SQW = 2 * OW + 1;        // sum of squares
   localparam int RW  = OW + 1;            // root width
   localparam int TW  = RW + CW;           // magnitude total
   localparam int RSTEPS = (SQW + 1) / 2;

   logic [CW-1:0] count_ff, count_in;
   logic signed [SW-1:0] min_i_ff, min_q_ff;
   logic [AW-1:0] ptr_ff;
   logic [OW-1:0] off_i_ff, off_q_ff;
   logic [TW-1:0] total_ff;
   logic [AW-1:0] wr_addr;

   assign wr_addr = count_ff[AW-1:0];
   assign count_in = count_ff + 1'b1;
   assign status.full = (count_in == CW'(DEPTH));
   assign status.ptr_last = ({1'b0, ptr_ff} == CW'(count_ff - 1'b1));

   // Sample count, minima and pass pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         if (cmd.load) begin
            count_ff <= count_in;
            if (count_ff == '0 || in_i < min_i_ff) min_i_ff <= in_i;
            if (count_ff == '0 || in_q < min_q_ff) min_q_ff <= in_q;
         end
         if (cmd.clear_ptr) begin
            ptr_ff <= '0;
         end else if (cmd.next_ptr) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
         if (cmd.out_load && last_flag) count_ff <= '0;
      end
   end

   // Stores for samples and magnitudes.
   logic [SW-1:0] rd_i, rd_q;
   logic [RW-1:0] rd_mag, root_val;
   iqed_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_ram_i (
      .clock, .wr_en(cmd.load), .wr_addr, .wr_data(in_i), .rd_addr(ptr_ff), .rd_data(rd_i));
   iqed_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_ram_q (
      .clock, .wr_en(cmd.load), .wr_addr, .wr_data(in_q), .rd_addr(ptr_ff), .rd_data(rd_q));
   iqed_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram_m (
      .clock, .wr_en(cmd.root_ok), .wr_addr(ptr_ff), .wr_data(root_val),
      .rd_addr(ptr_ff), .rd_data(rd_mag));

   // Offsets are fixed once the block is complete.
   always_ff @(posedge clock) begin
      if (cmd.clear_ptr && !cmd.start_div) begin
         off_i_ff <= '0;
         off_q_ff <= '0;
      end
      if (cmd.start_root && ptr_ff == '0) begin
         off_i_ff <= min_i_ff[SW-1] ? OW'(-$signed({min_i_ff[SW-1], min_i_ff})) : '0;
         off_q_ff <= min_q_ff[SW-1] ? OW'(-$signed({min_q_ff[SW-1], min_q_ff})) : '0;
      end
   end

   // Offset samples; the offsets for sample zero come straight from the minima.
   logic [OW-1:0] oi_use, oq_use, a_val, b_val;
   always_comb begin
      oi_use = off_i_ff;
      oq_use = off_q_ff;
      if (ptr_ff == '0) begin
         oi_use = min_i_ff[SW-1] ? OW'(-$signed({min_i_ff[SW-1], min_i_ff})) : '0;
         oq_use = min_q_ff[SW-1] ? OW'(-$signed({min_q_ff[SW-1], min_q_ff})) : '0;
      end
      a_val = OW'({rd_i[SW-1], rd_i}) + oi_use;
      b_val = OW'({rd_q[SW-1], rd_q}) + oq_use;
   end

   // Squares, then a bit-pair-per-cycle floor square root.
   logic [SQW-1:0] rem_ff, sq_sum;
   logic [SQW-1:0] res_ff, bit_ff;
   logic [$clog2(RSTEPS+1)-1:0] rstep_ff;
   logic sq_phase_ff, root_busy_ff;
   logic [2*OW-1:0] a_sq_ff, b_sq_ff;
   assign sq_sum = SQW'(a_sq_ff) + SQW'(b_sq_ff);
   assign root_val = RW'(res_ff);
   assign status.root_done = root_busy_ff && !sq_phase_ff && rstep_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_busy_ff <= 1'b0;
         sq_phase_ff  <= 1'b0;
      end else if (cmd.start_root) begin
         root_busy_ff <= 1'b1;
         sq_phase_ff  <= 1'b1;
      end else if (root_busy_ff && sq_phase_ff) begin
         sq_phase_ff <= 1'b0;
      end else if (cmd.root_ok) begin
         root_busy_ff <= 1'b0;
      end
      if (cmd.start_root) begin
         a_sq_ff <= a_val * a_val;
         b_sq_ff <= b_val * b_val;
      end else if (root_busy_ff && sq_phase_ff) begin
         rem_ff   <= sq_sum;
         res_ff   <= '0;
         bit_ff   <= SQW'(1) << (2 * (RSTEPS - 1));
         rstep_ff <= ($clog2(RSTEPS+1))'(RSTEPS);
      end else if (root_busy_ff && rstep_ff != '0) begin
         if (rem_ff >= res_ff + bit_ff) begin
            rem_ff <= rem_ff - (res_ff + bit_ff);
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff   <= bit_ff >> 2;
         rstep_ff <= rstep_ff - 1'b1;
      end
   end

   // Magnitude total.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cmd.root_ok) begin
         total_ff <= cmd.start_div ? '0 : total_ff + TW'(root_val);
      end
   end

   // Restoring division of total by count, one quotient bit per cycle.
   logic [TW-1:0] dq_ff, dr_ff, trial;
   logic [CW-1:0] dv_ff;
   logic [$clog2(TW+1)-1:0] dstep_ff;
   logic div_busy_ff;
   logic [TW:0] shifted;
   assign shifted = {dr_ff, dq_ff[TW-1]};
   assign trial = TW'(shifted - (TW+1)'(dv_ff));
   assign status.div_done = div_busy_ff && dstep_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.start_div) begin
         div_busy_ff <= 1'b1;
      end else if (status.div_done) begin
         div_busy_ff <= 1'b0;
      end
      if (cmd.start_div) begin
         dq_ff    <= total_ff + TW'(root_val);
         dr_ff    <= '0;
         dv_ff    <= count_ff;
         dstep_ff <= ($clog2(TW+1))'(TW);
      end else if (div_busy_ff && dstep_ff != '0) begin
         if (shifted >= (TW+1)'(dv_ff)) begin
            dr_ff <= trial;
            dq_ff <= {dq_ff[TW-2:0], 1'b1};
         end else begin
            dr_ff <= TW'(shifted);
            dq_ff <= {dq_ff[TW-2:0], 1'b0};
         end
         dstep_ff <= dstep_ff - 1'b1;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_data <= 18'(signed'({1'b0, rd_mag}) - signed'({1'b0, dq_ff}));
         rsp_last <= last_flag;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("count overflow");
   a_root_single: assert property (@(posedge clock) disable iff (reset)
      cmd.start_root |-> !root_busy_ff) else $error("root restarted");
   a_div_single: assert property (@(posedge clock) disable iff (reset)
      cmd.start_div |-> !div_busy_ff) else $error("divide restarted");
`endif
endmodule

### rtl/core/iq_envelope_demod_block.sv
// Channel  | Direction | Payload
// req      | in        | in_phase, quadrature, final_sample
// rsp      | out       | envelope_less_mean, end_of_block
// Loading accepts one sample per cycle. After the last sample each stored sample
// passes through a store read, a root launch, the squares, the bit-pair square
// root steps and a handoff. The mean divider then runs, and each result is
// read through the magnitude store read port before it is sent.
// Reset is synchronous and needs no clearing pass. A stalled result holds in
// the output register and the block waits; no sample is taken until the block ends.
module iq_envelope_demod_block import iqed_pkg::*; #(
   parameter int BLOCK_DEPTH  = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input logic clock,
   input logic reset,
   iqed_req_if.sink   req,
   iqed_rsp_if.source rsp
);
   cmd_type    cmd;
   status_type status;
   logic       last_flag;

   iqed_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_final(req.final_sample),
      .rsp_busy(rsp.valid), .rsp_ready(rsp.ready),
      .req_ready(req.ready), .last_flag, .status, .cmd);

   iqed_datapath #(.DEPTH(BLOCK_DEPTH), .SW(SAMPLE_WIDTH)) u_dp (
      .clock, .reset,
      .in_i(req.in_phase), .in_q(req.quadrature),
      .cmd, .last_flag, .rsp_ready(rsp.ready), .status,
      .rsp_valid(rsp.valid), .rsp_data(rsp.envelope_less_mean),
      .rsp_last(rsp.end_of_block));
endmodule
